### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers for the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define HSV2RGB_ASSERT(label, clk_i, rstn_i, prop, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);

// condition must never be seen outside reset
`define HSV2RGB_ASSERT_NEVER(label, clk_i, rstn_i, cond, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) else $error(msg);

`endif

### rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared constants and types of the hsv to rgb converter
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	localparam int CHANNEL_BITS_DEF = 8;
	localparam int HUE_BITS         = 15;
	localparam int FRAC_BITS        = 12;
	localparam int SECTOR_BITS      = 3;
	localparam int RAW_BITS         = 4;
	localparam int NUM_RAW          = 8;
	localparam int SECTORS          = 6;
	localparam int HUE_SECTOR       = 3840;
	// twice the sector width is 15 * 2^9
	localparam int HUE_SHIFT        = 9;
	localparam int SECTOR_ODD       = 15;

	typedef enum logic [SECTOR_BITS-1:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	typedef struct packed {
		logic first;
		logic second;
		logic third;
	} adv3_t;

endpackage

### rtl/hsv2rgb_hsv_if.sv
// ----------------------------------------------------------------------------
// hsv2rgb_hsv_if
// valid/ready channel carrying one hsv pixel
// ----------------------------------------------------------------------------
interface hsv2rgb_hsv_if #(
	parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	logic [hsv2rgb_pkg::HUE_BITS-1:0] hue;
	logic [CHANNEL_BITS-1:0]          saturation;
	logic [CHANNEL_BITS-1:0]          brightness;

	modport source (output valid, output hue, output saturation, output brightness, input ready);
	modport sink (input valid, input hue, input saturation, input brightness, output ready);
endinterface

### rtl/hsv2rgb_rgb_if.sv
// ----------------------------------------------------------------------------
// hsv2rgb_rgb_if
// valid/ready channel carrying one rgb pixel
// ----------------------------------------------------------------------------
interface hsv2rgb_rgb_if #(
	parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red;
	logic [CHANNEL_BITS-1:0] green;
	logic [CHANNEL_BITS-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

### rtl/hsv2rgb_sector.sv
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// first stage: hue wrap, sector number and fraction within the sector
// ----------------------------------------------------------------------------
module hsv2rgb_sector (
	input  logic                                clk,
	input  logic                                en,
	input  logic [hsv2rgb_pkg::HUE_BITS-1:0]    hue,
	output hsv2rgb_pkg::sector_t                sector_s1,
	output logic [hsv2rgb_pkg::FRAC_BITS-1:0]   frac_s1
);
	logic [hsv2rgb_pkg::RAW_BITS-1:0]  raw;
	logic [hsv2rgb_pkg::RAW_BITS-1:0]  sec_raw;
	logic [hsv2rgb_pkg::HUE_BITS-1:0]  base;
	logic [hsv2rgb_pkg::HUE_BITS-1:0]  diff;

	// sectors above a full turn fold back by six
	always_comb begin
		raw = '0;
		for (int k = 1; k <= hsv2rgb_pkg::NUM_RAW; k++) begin
			if (hue >= hsv2rgb_pkg::HUE_BITS'(k * hsv2rgb_pkg::HUE_SECTOR)) begin
				raw = raw + hsv2rgb_pkg::RAW_BITS'(1);
			end
		end
		base = hsv2rgb_pkg::HUE_BITS'(32'(raw) * hsv2rgb_pkg::HUE_SECTOR);
		diff = hue - base;
		if (raw >= hsv2rgb_pkg::RAW_BITS'(hsv2rgb_pkg::SECTORS)) begin
			sec_raw = raw - hsv2rgb_pkg::RAW_BITS'(hsv2rgb_pkg::SECTORS);
		end else begin
			sec_raw = raw;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sector_s1 <= hsv2rgb_pkg::sector_t'(sec_raw[hsv2rgb_pkg::SECTOR_BITS-1:0]);
			frac_s1   <= diff[hsv2rgb_pkg::FRAC_BITS-1:0];
		end
	end
endmodule

### rtl/hsv2rgb_prod.sv
// ----------------------------------------------------------------------------
// hsv2rgb_prod
// stages two to four: saturation products and rounded dividends
// ----------------------------------------------------------------------------
module hsv2rgb_prod #(
	parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
	input  logic                               clk,
	input  hsv2rgb_pkg::adv3_t                 adv,
	input  logic [CHANNEL_BITS-1:0]            sat_s1,
	input  logic [CHANNEL_BITS-1:0]            bri_s1,
	input  logic [hsv2rgb_pkg::FRAC_BITS-1:0]  frac_s1,
	output logic [2*CHANNEL_BITS:0]            yp_s4,
	output logic [2*CHANNEL_BITS+4:0]          yq_s4,
	output logic [2*CHANNEL_BITS+4:0]          yt_s4
);
	localparam int FB     = hsv2rgb_pkg::FRAC_BITS;
	localparam int VSW    = 2 * CHANNEL_BITS;
	localparam int AW     = VSW + FB;
	localparam int SW     = VSW + 14;
	localparam int YPW    = VSW + 1;
	localparam int CHMAX  = (1 << CHANNEL_BITS) - 1;
	localparam logic [SW-1:0]  DEN_M1 = SW'(hsv2rgb_pkg::HUE_SECTOR * CHMAX - 1);
	localparam logic [YPW-1:0] HALF_M = YPW'((CHMAX - 1) / 2);
	localparam logic [FB-1:0]  SEC_W  = FB'(hsv2rgb_pkg::HUE_SECTOR);

	logic [VSW-1:0] vs_s2;
	logic [FB-1:0]  frac_s2;
	logic [FB-1:0]  cfrac_s2;
	logic [AW-1:0]  aq_s3;
	logic [AW-1:0]  at_s3;
	logic [VSW-1:0] vs_s3;
	logic [SW-1:0]  sum_q;
	logic [SW-1:0]  sum_t;

	always_comb begin
		sum_q = (SW'(aq_s3) << 1) + DEN_M1;
		sum_t = (SW'(at_s3) << 1) + DEN_M1;
	end

	always_ff @(posedge clk) begin
		if (adv.first) begin
			vs_s2    <= VSW'(sat_s1) * VSW'(bri_s1);
			frac_s2  <= frac_s1;
			cfrac_s2 <= SEC_W - frac_s1;
		end
		if (adv.second) begin
			aq_s3 <= AW'(vs_s2) * AW'(frac_s2);
			at_s3 <= AW'(vs_s2) * AW'(cfrac_s2);
			vs_s3 <= vs_s2;
		end
		if (adv.third) begin
			yq_s4 <= sum_q[SW-1:hsv2rgb_pkg::HUE_SHIFT];
			yt_s4 <= sum_t[SW-1:hsv2rgb_pkg::HUE_SHIFT];
			yp_s4 <= YPW'(vs_s3) + HALF_M;
		end
	end
endmodule

### rtl/hsv2rgb_div.sv
// ----------------------------------------------------------------------------
// hsv2rgb_div
// three stage divider by a constant: reciprocal estimate, back product,
// one step correction
// ----------------------------------------------------------------------------
module hsv2rgb_div #(
	parameter int YW  = 21,
	parameter int QW  = 8,
	parameter int DIV = 3825
) (
	input  logic               clk,
	input  hsv2rgb_pkg::adv3_t adv,
	input  logic [YW-1:0]      y,
	output logic [QW-1:0]      quot_s3
);
	localparam int DW  = $clog2(DIV + 1);
	localparam int RW  = YW - DW + 1;
	localparam int PW  = YW + RW;
	localparam int QDW = QW + DW;
	localparam logic [RW-1:0] RECIP = RW'((65'd1 << YW) / DIV);
	localparam logic [YW-1:0] DIV_Y = YW'(DIV);

	logic [PW-1:0]  prod;
	logic [YW-1:0]  y_s1;
	logic [QW-1:0]  qe_s1;
	logic [YW-1:0]  y_s2;
	logic [QW-1:0]  qe_s2;
	logic [QDW-1:0] qd_s2;
	logic [YW-1:0]  rem;

	// estimate is the quotient or one below it
	always_comb begin
		prod = PW'(y) * PW'(RECIP);
		rem  = y_s2 - YW'(qd_s2);
	end

	always_ff @(posedge clk) begin
		if (adv.first) begin
			y_s1  <= y;
			qe_s1 <= prod[YW +: QW];
		end
		if (adv.second) begin
			y_s2  <= y_s1;
			qe_s2 <= qe_s1;
			qd_s2 <= QDW'(qe_s1) * QDW'(DIV);
		end
		if (adv.third) begin
			quot_s3 <= qe_s2 + QW'(rem >= DIV_Y);
		end
	end
endmodule

### rtl/hsv_to_rgb_convert.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert
// throughput: one pixel per cycle while the output is ready, through eight register stages
// each stage holds while it is full and its successor holds, so bubbles close up
// reset clears the stage valid bits only; datapath registers are not reset and keep their state
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_to_rgb_convert #(
	parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	hsv2rgb_hsv_if.sink      hsv,
	hsv2rgb_rgb_if.source    rgb
);
	localparam int STAGES = 8;
	localparam int CHMAX  = (1 << CHANNEL_BITS) - 1;
	localparam int YPW    = 2 * CHANNEL_BITS + 1;
	localparam int YQW    = 2 * CHANNEL_BITS + 5;

	logic                              en    [1:STAGES];
	logic                              vld_s [1:STAGES];
	logic [CHANNEL_BITS-1:0]           sat_s1;
	logic [CHANNEL_BITS-1:0]           bri_s [1:STAGES-1];
	hsv2rgb_pkg::sector_t              sector_s1;
	hsv2rgb_pkg::sector_t              sec_s [2:STAGES-1];
	logic [hsv2rgb_pkg::FRAC_BITS-1:0] frac_s1;
	logic [YPW-1:0]                    yp_s4;
	logic [YQW-1:0]                    yq_s4;
	logic [YQW-1:0]                    yt_s4;
	logic [CHANNEL_BITS-1:0]           quot_p;
	logic [CHANNEL_BITS-1:0]           quot_q;
	logic [CHANNEL_BITS-1:0]           quot_t;
	logic [CHANNEL_BITS-1:0]           p_val;
	logic [CHANNEL_BITS-1:0]           q_val;
	logic [CHANNEL_BITS-1:0]           t_val;
	logic [CHANNEL_BITS-1:0]           v_val;
	logic [CHANNEL_BITS-1:0]           red_d;
	logic [CHANNEL_BITS-1:0]           green_d;
	logic [CHANNEL_BITS-1:0]           blue_d;
	logic [CHANNEL_BITS-1:0]           red_s8;
	logic [CHANNEL_BITS-1:0]           green_s8;
	logic [CHANNEL_BITS-1:0]           blue_s8;
	hsv2rgb_pkg::adv3_t                adv_prod;
	hsv2rgb_pkg::adv3_t                adv_div;

	// a stage advances when empty or when the next one advances
	always_comb begin
		en[STAGES] = !vld_s[STAGES] || rgb.ready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign hsv.ready = en[1];
	assign adv_prod  = '{first: en[2], second: en[3], third: en[4]};
	assign adv_div   = '{first: en[5], second: en[6], third: en[7]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= STAGES; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			if (en[1]) begin
				vld_s[1] <= hsv.valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// brightness and sector ride along with the datapath
	always_ff @(posedge clk) begin
		if (en[1]) begin
			sat_s1   <= hsv.saturation;
			bri_s[1] <= hsv.brightness;
		end
		for (int k = 2; k <= STAGES - 1; k++) begin
			if (en[k]) begin
				bri_s[k] <= bri_s[k-1];
			end
		end
		if (en[2]) begin
			sec_s[2] <= sector_s1;
		end
		for (int k = 3; k <= STAGES - 1; k++) begin
			if (en[k]) begin
				sec_s[k] <= sec_s[k-1];
			end
		end
	end

	hsv2rgb_sector u_sector (
		.clk       (clk),
		.en        (en[1]),
		.hue       (hsv.hue),
		.sector_s1 (sector_s1),
		.frac_s1   (frac_s1)
	);

	hsv2rgb_prod #(
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_prod (
		.clk     (clk),
		.adv     (adv_prod),
		.sat_s1  (sat_s1),
		.bri_s1  (bri_s[1]),
		.frac_s1 (frac_s1),
		.yp_s4   (yp_s4),
		.yq_s4   (yq_s4),
		.yt_s4   (yt_s4)
	);

	hsv2rgb_div #(
		.YW  (YPW),
		.QW  (CHANNEL_BITS),
		.DIV (CHMAX)
	) u_div_p (
		.clk     (clk),
		.adv     (adv_div),
		.y       (yp_s4),
		.quot_s3 (quot_p)
	);

	hsv2rgb_div #(
		.YW  (YQW),
		.QW  (CHANNEL_BITS),
		.DIV (hsv2rgb_pkg::SECTOR_ODD * CHMAX)
	) u_div_q (
		.clk     (clk),
		.adv     (adv_div),
		.y       (yq_s4),
		.quot_s3 (quot_q)
	);

	hsv2rgb_div #(
		.YW  (YQW),
		.QW  (CHANNEL_BITS),
		.DIV (hsv2rgb_pkg::SECTOR_ODD * CHMAX)
	) u_div_t (
		.clk     (clk),
		.adv     (adv_div),
		.y       (yt_s4),
		.quot_s3 (quot_t)
	);

	// channel ordering per sector
	always_comb begin
		v_val = bri_s[STAGES-1];
		p_val = v_val - quot_p;
		q_val = v_val - quot_q;
		t_val = v_val - quot_t;
		unique case (sec_s[STAGES-1])
			hsv2rgb_pkg::SEC_RED: begin
				red_d = v_val; green_d = t_val; blue_d = p_val;
			end
			hsv2rgb_pkg::SEC_YELLOW: begin
				red_d = q_val; green_d = v_val; blue_d = p_val;
			end
			hsv2rgb_pkg::SEC_GREEN: begin
				red_d = p_val; green_d = v_val; blue_d = t_val;
			end
			hsv2rgb_pkg::SEC_CYAN: begin
				red_d = p_val; green_d = q_val; blue_d = v_val;
			end
			hsv2rgb_pkg::SEC_BLUE: begin
				red_d = t_val; green_d = p_val; blue_d = v_val;
			end
			hsv2rgb_pkg::SEC_MAGENTA: begin
				red_d = v_val; green_d = p_val; blue_d = q_val;
			end
			default: begin
				red_d = v_val; green_d = p_val; blue_d = q_val;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[STAGES]) begin
			red_s8   <= red_d;
			green_s8 <= green_d;
			blue_s8  <= blue_d;
		end
	end

	assign rgb.valid = vld_s[STAGES];
	assign rgb.red   = red_s8;
	assign rgb.green = green_s8;
	assign rgb.blue  = blue_s8;

	`HSV2RGB_ASSERT(a_quot_le_bri, clk, arst_n, vld_s[7] |-> (quot_p <= bri_s[7] && quot_q <= bri_s[7] && quot_t <= bri_s[7]), "subtrahend exceeds brightness")
	`HSV2RGB_ASSERT(a_p_smallest, clk, arst_n, vld_s[7] |-> (quot_p >= quot_q && quot_p >= quot_t), "p channel not the smallest")
	`HSV2RGB_ASSERT_NEVER(a_no_block, clk, arst_n, !vld_s[STAGES] && !hsv.ready, "input blocked with empty output stage")
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the hsv to rgb pixel converter: a table of
// directed pixels (primary colors, grey, black, hue wrap) followed by
// random pixels, each compared channel by channel against a typed-in
// result or an in-bench fixed-point model, with random gaps on both sides
// and one long output stall that backs the pipeline up into its input
// ----------------------------------------------------------------------------
module tb;
	import hsv2rgb_pkg::*;

	localparam int CH             = CHANNEL_BITS_DEF;
	localparam int HUE_TURN       = SECTORS * HUE_SECTOR;
	localparam int RX_HOLD_CYCLES = 64;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PRINT_LIMIT    = 40;

	typedef logic [CH-1:0] chan_t;

	typedef struct packed {
		logic [HUE_BITS-1:0] hue;
		chan_t               saturation;
		chan_t               brightness;
	} hsv_pixel_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_pixel_t;

	// pixel in, flag for a typed-in result, result
	typedef struct packed {
		hsv_pixel_t px;
		logic       typed;
		rgb_pixel_t want;
	} stim_row_t;

	localparam int NUM_DIRECTED = 24;
	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		{15'd0,     8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
		{15'd3840,  8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd0},
		{15'd7680,  8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0},
		{15'd11520, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd255},
		{15'd15360, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
		{15'd19200, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd255},
		{15'd23040, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
		{15'd0,     8'd255, 8'd128, 1'b1, 8'd128, 8'd0,   8'd0},
		{15'd12345, 8'd0,   8'd77,  1'b1, 8'd77,  8'd77,  8'd77},
		{15'd32767, 8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
		{15'd5000,  8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
		{15'd0,     8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
		{15'd3839,  8'd255, 8'd255, 1'b0, 24'd0},
		{15'd23039, 8'd255, 8'd255, 1'b0, 24'd0},
		{15'd23041, 8'd255, 8'd255, 1'b0, 24'd0},
		{15'd32767, 8'd255, 8'd255, 1'b0, 24'd0},
		{15'd1,     8'd1,   8'd1,   1'b0, 24'd0},
		{15'd1920,  8'd128, 8'd200, 1'b0, 24'd0},
		{15'd9727,  8'd170, 8'd85,  1'b0, 24'd0},
		{15'd16384, 8'd85,  8'd170, 1'b0, 24'd0},
		{15'd7679,  8'd1,   8'd254, 1'b0, 24'd0},
		{15'd21000, 8'd254, 8'd1,   1'b0, 24'd0},
		{15'd11519, 8'd100, 8'd255, 1'b0, 24'd0},
		{15'd25000, 8'd200, 8'd100, 1'b0, 24'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	hsv2rgb_hsv_if #(.CHANNEL_BITS(CH)) hsv_ch ();
	hsv2rgb_rgb_if #(.CHANNEL_BITS(CH)) rgb_ch ();

	hsv_to_rgb_convert #(.CHANNEL_BITS(CH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv_ch),
		.rgb    (rgb_ch)
	);

	rgb_pixel_t  pending_rgb [$];
	int unsigned mismatch_count = 0;
	bit          sender_gaps    = 1'b0;
	bit          receiver_gaps  = 1'b0;
	bit          long_hold      = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned round_half_up(input longint unsigned num,
		input longint unsigned den);
		return (2 * num + den) / (2 * den);
	endfunction

	function automatic rgb_pixel_t convert_hsv(input hsv_pixel_t px);
		longint unsigned full, h, s, v, frac, den, p, q, t;
		sector_t         sec;
		rgb_pixel_t      res;
		full = (longint'(1) << CH) - 1;
		h    = 64'(px.hue);
		s    = 64'(px.saturation);
		v    = 64'(px.brightness);
		if (h >= HUE_TURN) begin
			h = h - HUE_TURN;
		end
		if (s == 0) begin
			res = {chan_t'(v), chan_t'(v), chan_t'(v)};
		end else begin
			sec  = sector_t'(h / HUE_SECTOR);
			frac = h % HUE_SECTOR;
			den  = full * HUE_SECTOR;
			p    = round_half_up(v * (full - s), full);
			q    = round_half_up(v * (den - s * frac), den);
			t    = round_half_up(v * (den - s * (HUE_SECTOR - frac)), den);
			case (sec)
				SEC_RED: begin
					res = {chan_t'(v), chan_t'(t), chan_t'(p)};
				end
				SEC_YELLOW: begin
					res = {chan_t'(q), chan_t'(v), chan_t'(p)};
				end
				SEC_GREEN: begin
					res = {chan_t'(p), chan_t'(v), chan_t'(t)};
				end
				SEC_CYAN: begin
					res = {chan_t'(p), chan_t'(q), chan_t'(v)};
				end
				SEC_BLUE: begin
					res = {chan_t'(t), chan_t'(p), chan_t'(v)};
				end
				default: begin
					res = {chan_t'(v), chan_t'(p), chan_t'(q)};
				end
			endcase
		end
		return res;
	endfunction

	function automatic chan_t pick_channel();
		int unsigned sel;
		sel = $urandom_range(0, 7);
		if (sel == 0) begin
			return '0;
		end else if (sel == 1) begin
			return '1;
		end
		return chan_t'($urandom);
	endfunction

	function automatic hsv_pixel_t pick_pixel();
		int unsigned sel;
		hsv_pixel_t  px;
		sel = $urandom_range(0, 9);
		if (sel <= 5) begin
			px.hue = HUE_BITS'($urandom_range(0, HUE_TURN - 1));
		end else if (sel == 6) begin
			// straddle a sector boundary
			px.hue = HUE_BITS'($urandom_range(1, SECTORS) * HUE_SECTOR - 1
				+ $urandom_range(0, 2));
		end else if (sel == 7) begin
			px.hue = HUE_BITS'($urandom_range(HUE_TURN, (1 << HUE_BITS) - 1));
		end else if (sel == 8) begin
			px.hue = HUE_BITS'($urandom);
		end else begin
			px.hue = HUE_BITS'(HUE_TURN);
		end
		px.saturation = pick_channel();
		px.brightness = pick_channel();
		return px;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("mismatch at %0t ns: %s", $time, msg);
		end
	endtask

	task automatic check_channel(input string name, input chan_t got, input chan_t want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	task automatic transfer_pixel(input hsv_pixel_t px, input rgb_pixel_t want);
		hsv_ch.valid      <= 1'b1;
		hsv_ch.hue        <= px.hue;
		hsv_ch.saturation <= px.saturation;
		hsv_ch.brightness <= px.brightness;
		do begin
			@(posedge clk);
		end while (!hsv_ch.ready);
		pending_rgb.push_back(want);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			hsv_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic send_random(input int unsigned count);
		hsv_pixel_t px;
		repeat (count) begin
			px = pick_pixel();
			transfer_pixel(px, convert_hsv(px));
		end
	endtask

	// output side: ready bursts and the long hold
	initial begin
		rgb_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rgb_ch.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
				rgb_ch.ready <= 1'b1;
			end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
				rgb_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				rgb_ch.ready <= 1'b1;
			end else begin
				rgb_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rgb_pixel_t want;
		if (arst_n && rgb_ch.valid && rgb_ch.ready) begin
			if (pending_rgb.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel r=%0d g=%0d b=%0d",
					rgb_ch.red, rgb_ch.green, rgb_ch.blue));
			end else begin
				want = pending_rgb.pop_front();
				check_channel("red", rgb_ch.red, want.red);
				check_channel("green", rgb_ch.green, want.green);
				check_channel("blue", rgb_ch.blue, want.blue);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n            <= 1'b0;
		hsv_ch.valid      <= 1'b0;
		hsv_ch.hue        <= '0;
		hsv_ch.saturation <= '0;
		hsv_ch.brightness <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
		foreach (DIRECTED[i]) begin
			transfer_pixel(DIRECTED[i].px,
				DIRECTED[i].typed ? DIRECTED[i].want : convert_hsv(DIRECTED[i].px));
		end
		send_random(450);

		// back-to-back input against a stalled output
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		long_hold     = 1'b1;
		send_random(40);

		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
		send_random(100);

		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		send_random(100);
		hsv_ch.valid <= 1'b0;

		while (pending_rgb.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
